>>> rtl/iq2_pkg.sv
// Package for the IQ2_XXS codebook dequantizer: beat structs, level ROM,
// and float helpers. No dependencies.
package iq2_pkg;

    typedef struct packed {
        logic [15:0] block_scale_half;
        logic [31:0] index_word;
        logic [31:0] sign_scale_word;
        logic        final_group;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] value_0;
        logic [31:0] value_1;
        logic [31:0] value_2;
        logic [31:0] value_3;
        logic [31:0] value_4;
        logic [31:0] value_5;
        logic [31:0] value_6;
        logic [31:0] value_7;
        logic [1:0]  subgroup;
        logic        last_of_group;
        logic        end_of_stream;
    } t_out_beat;

    localparam logic [31:0] F32_QNAN = 32'h7FC0_0000;
    localparam logic [31:0] F32_INF  = 32'h7F80_0000;

    function automatic logic [15:0] level_rom(input logic [7:0] a);
        logic [15:0] t [256];
        t = '{
            16'd0,16'd2,16'd5,16'd8,16'd10,16'd17,16'd20,16'd32,16'd34,16'd40,16'd42,
            16'd65,16'd68,16'd80,16'd88,16'd97,16'd100,16'd128,16'd130,16'd138,16'd162,
            16'd257,16'd260,16'd272,16'd277,16'd320,16'd388,16'd408,16'd512,16'd514,
            16'd546,16'd642,16'd1025,16'd1028,16'd1040,16'd1057,16'd1060,16'd1088,
            16'd1090,16'd1096,16'd1120,16'd1153,16'd1156,16'd1168,16'd1188,16'd1280,
            16'd1282,16'd1288,16'd1312,16'd1350,16'd1385,16'd1408,16'd1425,16'd1545,
            16'd1552,16'd1600,16'd1668,16'd1700,16'd2048,16'd2053,16'd2056,16'd2068,
            16'd2088,16'd2113,16'd2116,16'd2128,16'd2130,16'd2184,16'd2308,16'd2368,
            16'd2562,16'd2580,16'd4097,16'd4100,16'd4112,16'd4129,16'd4160,16'd4192,
            16'd4228,16'd4240,16'd4245,16'd4352,16'd4360,16'd4384,16'd4432,16'd4442,
            16'd4480,16'd4644,16'd4677,16'd5120,16'd5128,16'd5152,16'd5157,16'd5193,
            16'd5248,16'd5400,16'd5474,16'd5632,16'd5654,16'd6145,16'd6148,16'd6160,
            16'd6208,16'd6273,16'd6400,16'd6405,16'd6560,16'd6737,16'd8192,16'd8194,
            16'd8202,16'd8260,16'd8289,16'd8320,16'd8322,16'd8489,16'd8520,16'd8704,
            16'd8706,16'd9217,16'd9220,16'd9232,16'd9280,16'd9302,16'd9472,16'd9537,
            16'd9572,16'd9872,16'd10248,16'd10272,16'd10388,16'd10820,16'd16385,
            16'd16388,16'd16400,16'd16408,16'd16417,16'd16420,16'd16448,16'd16456,
            16'd16470,16'd16480,16'd16513,16'd16516,16'd16528,16'd16640,16'd16672,
            16'd16737,16'd16768,16'd16773,16'd16897,16'd16912,16'd16968,16'd16982,
            16'd17000,16'd17408,16'd17416,16'd17440,16'd17536,16'd17561,16'd17682,
            16'd17700,16'd17920,16'd18433,16'd18436,16'd18448,16'd18496,16'd18501,
            16'd18688,16'd18776,16'd18785,16'd18818,16'd19013,16'd19088,16'd20480,
            16'd20488,16'd20497,16'd20505,16'd20512,16'd20608,16'd20616,16'd20740,
            16'd20802,16'd20900,16'd21137,16'd21648,16'd21650,16'd21770,16'd22017,
            16'd22100,16'd22528,16'd22545,16'd22553,16'd22628,16'd22848,16'd23048,
            16'd24580,16'd24592,16'd24640,16'd24680,16'd24832,16'd24917,16'd25112,
            16'd25184,16'd25600,16'd25605,16'd25872,16'd25874,16'd25988,16'd26690,
            16'd32768,16'd32770,16'd32778,16'd32833,16'd32898,16'd33028,16'd33048,
            16'd33088,16'd33297,16'd33793,16'd33796,16'd33808,16'd33813,16'd33856,
            16'd33888,16'd34048,16'd34118,16'd34196,16'd34313,16'd34368,16'd34400,
            16'd34818,16'd35076,16'd35345,16'd36868,16'd36880,16'd36900,16'd36928,
            16'd37025,16'd37142,16'd37248,16'd37445,16'd37888,16'd37922,16'd37956,
            16'd38225,16'd39041,16'd39200,16'd40962,16'd41040,16'd41093,16'd41225,
            16'd41472,16'd42008,16'd43088,16'd43268
        };
        return t[a];
    endfunction

endpackage

>>> rtl/iq2xxs_codebook_dequantizer_core.sv
// Top level of the IQ2_XXS codebook dequantizer: input register, scale
// pipeline, subgroup sequencer, eight lanes and output register.
// The result beats of a group come out one per cycle.
// A new group may start before the last group's results are all out.
// Reset (synchronous, active low) clears all valid and sequencer state.
// Results are strobed for one cycle; the receiver cannot stall them.
module iq2xxs_codebook_dequantizer_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  iq2_pkg::t_in_beat i_item,
    output logic              o_strobe,
    output iq2_pkg::t_out_beat o_result
);
    logic [1:0]  r_cnt;
    logic        r_act;
    logic        accept;
    iq2_pkg::t_in_beat r_q0, r_q1;
    logic        s_valid, s_sign, s_zero, s_inf, s_nan;
    logic [8:0]  s_exp;
    logic [15:0] s_mant;
    logic [1:0]  r_sub;
    logic        r_run;
    logic [15:0] entry;
    logic [7:0]  signs;
    logic [6:0]  code;
    logic [31:0] lane_bits [8];
    iq2_pkg::t_out_beat n_res, r_res;
    logic        r_str;

    assign accept = start && !busy;
    assign busy   = r_act;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_cnt <= 2'd0;
        end else if (accept) begin
            r_act <= 1'b1;
            r_cnt <= 2'd0;
        end else if (r_act) begin
            r_cnt <= r_cnt + 2'd1;
            if (r_cnt == 2'd2) begin
                r_act <= 1'b0;
            end
        end
        if (accept) begin
            r_q0 <= i_item;
        end
        r_q1 <= r_q0;
    end

    iq2_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_half  (i_item.block_scale_half),
        .i_gscale(i_item.sign_scale_word[31:28]),
        .o_valid (s_valid),
        .o_sign  (s_sign),
        .o_zero  (s_zero),
        .o_inf   (s_inf),
        .o_nan   (s_nan),
        .o_exp   (s_exp),
        .o_mant  (s_mant)
    );

    logic        r_hs, r_hz, r_hi, r_hn;
    logic [8:0]  r_he;
    logic [15:0] r_hm;
    logic [31:0] r_idx, r_sgn;
    logic        r_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_sub <= 2'd0;
        end else if (s_valid) begin
            r_run <= 1'b1;
            r_sub <= 2'd0;
        end else if (r_run) begin
            r_sub <= r_sub + 2'd1;
            if (r_sub == 2'd3) begin
                r_run <= 1'b0;
            end
        end
        if (s_valid) begin
            r_hs  <= s_sign;
            r_hz  <= s_zero;
            r_hi  <= s_inf;
            r_hn  <= s_nan;
            r_he  <= s_exp;
            r_hm  <= s_mant;
            r_idx <= r_q1.index_word;
            r_sgn <= r_q1.sign_scale_word;
            r_fin <= r_q1.final_group;
        end
    end

    always_comb begin
        entry = iq2_pkg::level_rom(r_idx[8*r_sub +: 8]);
        code  = r_sgn[7*r_sub +: 7];
        signs = {^code, code};
    end

    for (genvar j = 0; j < 8; j++) begin : g_lane
        iq2_lane u_lane (
            .i_sign(r_hs),
            .i_zero(r_hz),
            .i_inf (r_hi),
            .i_nan (r_hn),
            .i_exp (r_he),
            .i_mant(r_hm),
            .i_lvl (entry[2*j +: 2]),
            .i_neg (signs[j]),
            .o_bits(lane_bits[j])
        );
    end

    always_comb begin
        n_res.value_0 = lane_bits[0];
        n_res.value_1 = lane_bits[1];
        n_res.value_2 = lane_bits[2];
        n_res.value_3 = lane_bits[3];
        n_res.value_4 = lane_bits[4];
        n_res.value_5 = lane_bits[5];
        n_res.value_6 = lane_bits[6];
        n_res.value_7 = lane_bits[7];
        n_res.subgroup = r_sub;
        n_res.last_of_group = (r_sub == 2'd3);
        n_res.end_of_stream = (r_sub == 2'd3) && r_fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_str <= 1'b0;
        end else begin
            r_str <= r_run;
        end
        r_res <= n_res;
    end

    assign o_strobe = r_str;
    assign o_result = r_res;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy) else $error("busy not raised after accept");
    a_run_follows_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_valid |=> r_run && r_sub == 2'd0) else $error("sequencer did not start");
    a_last_on_three: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.last_of_group |-> o_result.subgroup == 2'd3)
        else $error("last flag off subgroup three");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_valid |-> !r_run || r_sub == 2'd3) else $error("groups overlap");
endmodule

>>> rtl/iq2_scale.sv
// Scale stage: turns the half scale into a normalized f32 significand and
// exponent, then multiplies by 2*s+1. No package dependencies.
module iq2_scale (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [15:0] i_half,
    input  logic [3:0]  i_gscale,
    output logic        o_valid,
    output logic        o_sign,
    output logic        o_zero,
    output logic        o_inf,
    output logic        o_nan,
    output logic [8:0]  o_exp,
    output logic [15:0] o_mant
);
    logic        r_v1, r_v2;
    logic        r_s1, r_z1, r_i1, r_n1, r_s2, r_z2, r_i2, r_n2;
    logic [8:0]  r_e1, r_e2;
    logic [10:0] r_m1;
    logic [4:0]  r_k1;
    logic [15:0] r_p2;
    logic [10:0] n_m1;
    logic [8:0]  n_e1;
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [3:0]  lz;

    assign ex  = i_half[14:10];
    assign man = i_half[9:0];

    always_comb begin
        lz = 4'd0;
        for (int b = 9; b >= 0; b--) begin
            if (man[b] && lz == 4'd0 && (man >> (b + 1)) == 10'd0) begin
                lz = 4'(10 - b);
            end
        end
        if (ex == 5'd0) begin
            n_m1 = {1'b0, man} << lz;
            n_e1 = 9'd113 - 9'(lz);
        end else begin
            n_m1 = {1'b1, man};
            n_e1 = 9'(ex) + 9'd112;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        r_s1 <= i_half[15];
        r_z1 <= (ex == 5'd0) && (man == 10'd0);
        r_i1 <= (ex == 5'd31) && (man == 10'd0);
        r_n1 <= (ex == 5'd31) && (man != 10'd0);
        r_m1 <= n_m1;
        r_e1 <= n_e1;
        r_k1 <= {i_gscale, 1'b1};
        r_s2 <= r_s1;
        r_z2 <= r_z1;
        r_i2 <= r_i1;
        r_n2 <= r_n1;
        r_e2 <= r_e1;
        r_p2 <= 16'(r_m1) * 16'(r_k1);
    end

    assign o_valid = r_v2;
    assign o_sign  = r_s2;
    assign o_zero  = r_z2;
    assign o_inf   = r_i2;
    assign o_nan   = r_n2;
    assign o_exp   = r_e2;
    assign o_mant  = r_p2;
endmodule

>>> rtl/iq2_lane.sv
// One weight lane: multiplies the scaled significand by 2l+1, normalizes,
// and packs f32 bits. Depends on iq2_pkg.
module iq2_lane (
    input  logic        i_sign,
    input  logic        i_zero,
    input  logic        i_inf,
    input  logic        i_nan,
    input  logic [8:0]  i_exp,
    input  logic [15:0] i_mant,
    input  logic [1:0]  i_lvl,
    input  logic        i_neg,
    output logic [31:0] o_bits
);
    logic [18:0] prod;
    logic [4:0]  top;
    logic        s;
    logic [8:0]  e;
    logic [22:0] frac;

    always_comb begin
        prod = 19'(i_mant) * 19'({i_lvl, 1'b1});
        top  = 5'd0;
        for (int b = 0; b < 19; b++) begin
            if (prod[b]) begin
                top = 5'(b);
            end
        end
        s = i_sign ^ i_neg;
        e = i_exp + 9'(top) - 9'd10;
        frac = 23'((42'(prod) << (23 - top)));
        if (i_nan) begin
            o_bits = iq2_pkg::F32_QNAN;
        end else if (i_inf) begin
            o_bits = {s, iq2_pkg::F32_INF[30:0]};
        end else if (i_zero) begin
            o_bits = {s, 31'd0};
        end else begin
            o_bits = {s, e[7:0], frac};
        end
    end
endmodule
